@@ rtl/core/bpf_pkg.sv @@
// Shared types, register codes and arithmetic helpers for the biquad filter.
`timescale 1ns / 1ps

package bpf_pkg;

  localparam int SampleW = 16;
  localparam int CoefW   = 24;
  localparam int StateW  = 40;
  localparam int ProdW   = CoefW + StateW;
  localparam int AccW    = 46;
  localparam int IdxW    = 3;
  localparam int FracSh  = 20;

  localparam logic signed [CoefW-1:0] CoefOne = 24'sd1048576;
  localparam logic signed [AccW-1:0]  StMax   = 46'sd549755813887;
  localparam logic signed [AccW-1:0]  StMin   = -46'sd549755813888;

  typedef enum logic [IdxW-1:0] {
    REG_ENABLE  = 3'd0,
    REG_COEF_B0 = 3'd1,
    REG_COEF_B1 = 3'd2,
    REG_COEF_B2 = 3'd3,
    REG_COEF_A1 = 3'd4,
    REG_COEF_A2 = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic                    enable;
    logic signed [CoefW-1:0] b0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] a1;
    logic signed [CoefW-1:0] a2;
  } coefs_t;

  typedef enum logic [2:0] {
    MUL_B0X,
    MUL_B1X,
    MUL_B2X,
    MUL_A1Y,
    MUL_A2Y
  } mul_sel_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_Y,
    OP_ACC1_START,
    OP_ACC1_FB,
    OP_ACC2_START,
    OP_FINISH,
    OP_PASS
  } dp_op_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t mul_sel;
    logic     prod_en;
  } dp_cmd_t;

  // Saturate a wide intermediate to the signed 40-bit state range.
  function automatic logic signed [StateW-1:0] sat40(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] r;
    begin
      if (v > StMax) begin
        r = StMax;
      end else if (v < StMin) begin
        r = StMin;
      end else begin
        r = v;
      end
      sat40 = r[StateW-1:0];
    end
  endfunction

endpackage

@@ rtl/core/bpf_cfg.sv @@
// Configuration register bank: enable flag and the five filter coefficients.
`timescale 1ns / 1ps

module bpf_cfg
  import bpf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IdxW-1:0]         cfg_index,
  input  logic [CoefW-1:0]        cfg_data,
  output coefs_t                  coefs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs.enable <= 1'b0;
      coefs.b0     <= CoefOne;
      coefs.b1     <= '0;
      coefs.b2     <= '0;
      coefs.a1     <= '0;
      coefs.a2     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:  coefs.enable <= cfg_data[0];
        REG_COEF_B0: coefs.b0     <= cfg_data;
        REG_COEF_B1: coefs.b1     <= cfg_data;
        REG_COEF_B2: coefs.b2     <= cfg_data;
        REG_COEF_A1: coefs.a1     <= cfg_data;
        REG_COEF_A2: coefs.a2     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/bpf_ctrl.sv @@
// Sequencer that steps the shared multiplier through one filter update.
`timescale 1ns / 1ps

module bpf_ctrl
  import bpf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  logic    enable,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_B0,
    S_MUL_B1,
    S_MUL_A1,
    S_MUL_B2,
    S_MUL_A2,
    S_FINISH,
    S_PASS
  } state_t;

  state_t state;
  logic   slot_free;
  logic   take;

  assign in_ready  = (state == S_IDLE);
  assign take      = in_valid && in_ready;
  // The output register can be reloaded when empty or when its transfer happens now.
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd = '{op: OP_NONE, mul_sel: MUL_B0X, prod_en: 1'b0};
    case (state)
      S_IDLE:   if (take) cmd.op = OP_LOAD;
      S_MUL_B0: cmd = '{op: OP_NONE,       mul_sel: MUL_B0X, prod_en: 1'b1};
      S_MUL_B1: cmd = '{op: OP_Y,          mul_sel: MUL_B1X, prod_en: 1'b1};
      S_MUL_A1: cmd = '{op: OP_ACC1_START, mul_sel: MUL_A1Y, prod_en: 1'b1};
      S_MUL_B2: cmd = '{op: OP_ACC1_FB,    mul_sel: MUL_B2X, prod_en: 1'b1};
      S_MUL_A2: cmd = '{op: OP_ACC2_START, mul_sel: MUL_A2Y, prod_en: 1'b1};
      S_FINISH: if (slot_free) cmd.op = OP_FINISH;
      S_PASS:   if (slot_free) cmd.op = OP_PASS;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In the finishing states a transfer is followed at once by the next result.
      if (out_valid && out_ready && !(state inside {S_FINISH, S_PASS})) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            state <= enable ? S_MUL_B0 : S_PASS;
          end
        end
        S_MUL_B0: state <= S_MUL_B1;
        S_MUL_B1: state <= S_MUL_A1;
        S_MUL_A1: state <= S_MUL_B2;
        S_MUL_B2: state <= S_MUL_A2;
        S_MUL_A2: state <= S_FINISH;
        S_FINISH, S_PASS: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/bpf_dp.sv @@
// Datapath: shared multiplier, accumulators, delay state and output register.
`timescale 1ns / 1ps

module bpf_dp
  import bpf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  input  coefs_t                    coefs,
  input  logic signed [SampleW-1:0] sample_in,
  input  logic                      clear_state,
  output logic signed [SampleW-1:0] sample_out,
  output logic                      clipped
);

  logic signed [SampleW-1:0] x;
  logic signed [StateW-1:0]  y;
  logic signed [StateW-1:0]  delay_one;
  logic signed [StateW-1:0]  delay_two;
  logic signed [AccW-1:0]    acc1;
  logic signed [AccW-1:0]    acc2;
  logic signed [ProdW-1:0]   prod;

  logic signed [CoefW-1:0]   mul_a;
  logic signed [StateW-1:0]  mul_b;
  logic signed [ProdW-1:0]   mul_p;
  logic signed [StateW-1:0]  x_ext;
  logic signed [ProdW-1:0]   prod_rnd;
  logic signed [AccW-1:0]    fb;
  logic signed [AccW-1:0]    y_sum;
  logic signed [AccW-1:0]    n2;
  logic signed [StateW:0]    y_rnd;
  logic signed [SampleW+4:0] q;
  logic signed [SampleW-1:0] q_sat;
  logic                      q_clip;

  assign x_ext = StateW'(x);

  always_comb begin
    case (cmd.mul_sel)
      MUL_B0X: begin mul_a = coefs.b0; mul_b = x_ext; end
      MUL_B1X: begin mul_a = coefs.b1; mul_b = x_ext; end
      MUL_B2X: begin mul_a = coefs.b2; mul_b = x_ext; end
      MUL_A1Y: begin mul_a = coefs.a1; mul_b = y;     end
      MUL_A2Y: begin mul_a = coefs.a2; mul_b = y;     end
      default: begin mul_a = '0;       mul_b = '0;    end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Feedback products come back to the state scale with round half up.
  assign prod_rnd = prod + ProdW'(64'sd524288);
  assign fb       = AccW'($signed(prod_rnd[ProdW-1:FracSh]));

  assign y_sum = AccW'($signed(prod[StateW-1:0])) + AccW'(delay_one);
  assign n2    = acc2 - fb;

  assign y_rnd = StateW'(y) + (StateW+1)'(524288);
  assign q     = y_rnd[StateW:FracSh];

  always_comb begin
    if (q > (SampleW+5)'(32767)) begin
      q_sat  = 16'sh7fff;
      q_clip = 1'b1;
    end else if (q < -(SampleW+5)'(32768)) begin
      q_sat  = 16'sh8000;
      q_clip = 1'b1;
    end else begin
      q_sat  = q[SampleW-1:0];
      q_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod <= mul_p;
    end
    case (cmd.op)
      OP_LOAD:       x    <= sample_in;
      OP_Y:          y    <= sat40(y_sum);
      OP_ACC1_START: acc1 <= AccW'($signed(prod[StateW-1:0])) + AccW'(delay_two);
      OP_ACC1_FB:    acc1 <= acc1 - fb;
      OP_ACC2_START: acc2 <= AccW'($signed(prod[StateW-1:0]));
      OP_FINISH: begin
        sample_out <= q_sat;
        clipped    <= q_clip;
      end
      OP_PASS: begin
        sample_out <= x;
        clipped    <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (cmd.op == OP_LOAD && clear_state) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (cmd.op == OP_FINISH) begin
      delay_one <= sat40(acc1);
      delay_two <= sat40(n2);
    end
  end

endmodule

@@ rtl/core/biquad_peaking_filter.sv @@
// Top level of the fixed-point biquad filter section.
`timescale 1ns / 1ps

// Second-order IIR section in transposed direct form II on signed Q1.15 samples,
// with Q4.20 coefficients and 40-bit delay state. With filtering enabled one
// multiplier of 24 by 40 bits is shared by the five products b0*x, b1*x, a1*y,
// b2*x and a2*y, one each cycle, followed by a finishing step that updates the
// delay state and loads the output register once that register is free. With
// filtering disabled the sample is passed straight to the output register. A new
// sample is taken as soon as the previous result sits in the output register, and
// configuration writes complete in the cycle they are offered.
module biquad_peaking_filter
  import bpf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SampleW-1:0] sample_in,
  input  logic                      clear_state,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SampleW-1:0] sample_out,
  output logic                      clipped,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [IdxW-1:0]           cfg_index,
  input  logic [CoefW-1:0]          cfg_data
);

  coefs_t  coefs;
  dp_cmd_t cmd;

  bpf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coefs     (coefs)
  );

  bpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .enable    (coefs.enable),
    .cmd       (cmd)
  );

  bpf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .coefs       (coefs),
    .sample_in   (sample_in),
    .clear_state (clear_state),
    .sample_out  (sample_out),
    .clipped     (clipped)
  );

`ifndef SYNTHESIS
  // Only one sample is in flight, so an input transfer closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is still in work");

  // A clipped result must sit on one of the two saturation limits.
  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (sample_out == 16'sh7fff || sample_out == 16'sh8000))
    else $error("clip flag raised on an unsaturated result");

  // Reset leaves no result pending and the input side open.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");
`endif

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the biquad filter, driving random and directed audio samples.
`timescale 1ns / 1ps

module tb_top;
  import bpf_pkg::*;

  localparam int StallLimit = 5000;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 106;
  localparam logic [IdxW-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [IdxW-1:0] IDX_SPARE_HI = 3'd7;

  localparam int GapPct[4]    = '{0, 66, 0, 7};
  localparam int StallPct[4]  = '{0, 0, 66, 7};
  // Coefficient style per random phase: 0 full range, 1 moderate, 2 extremes, 3 bypassed.
  localparam int PhaseKind[8] = '{1, 0, 2, 1, 3, 1, 0, 2};

  typedef struct packed {
    logic signed [SampleW-1:0] smp;
    logic                      clr;
  } audio_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] smp;
    logic                      clip;
  } audio_res_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [SampleW-1:0] sample_in = '0;
  logic                      clear_state = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SampleW-1:0] sample_out;
  logic                      clipped;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [IdxW-1:0]           cfg_index = '0;
  logic [CoefW-1:0]          cfg_data = '0;

  // Predictor copy of the configuration and the delay state.
  logic                     filt_on = 1'b0;
  logic signed [CoefW-1:0]  cb0 = CoefOne;
  logic signed [CoefW-1:0]  cb1 = '0;
  logic signed [CoefW-1:0]  cb2 = '0;
  logic signed [CoefW-1:0]  ca1 = '0;
  logic signed [CoefW-1:0]  ca2 = '0;
  logic signed [StateW-1:0] z1 = '0;
  logic signed [StateW-1:0] z2 = '0;

  audio_item_t pending_samples[$];
  audio_res_t  due_outputs[$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  bit hold_arm = 1'b0;
  int mismatches = 0;
  int outputs_seen = 0;
  int idle_cycles = 0;

  biquad_peaking_filter u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .clear_state (clear_state),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .clipped     (clipped),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp_state(input longint v);
    if (v > 64'sd549755813887) return 64'sd549755813887;
    if (v < -64'sd549755813888) return -64'sd549755813888;
    return v;
  endfunction

  // Round half up from scale 2^-55 (or 2^-35) down by twenty fraction bits.
  function automatic longint round_q20(input longint v);
    return (v + 64'sd524288) >>> FracSh;
  endfunction

  function automatic audio_res_t filter_sample(input audio_item_t it);
    longint x, y, n1, n2, q;
    audio_res_t r;
    x = longint'(it.smp);
    if (it.clr) begin
      z1 = '0;
      z2 = '0;
    end
    if (!filt_on) begin
      r.smp = it.smp;
      r.clip = 1'b0;
      return r;
    end
    y  = clamp_state(longint'(cb0) * x + longint'(z1));
    n1 = longint'(cb1) * x - round_q20(longint'(ca1) * y) + longint'(z2);
    n2 = longint'(cb2) * x - round_q20(longint'(ca2) * y);
    z1 = StateW'(clamp_state(n1));
    z2 = StateW'(clamp_state(n2));
    q  = round_q20(y);
    r.clip = 1'b1;
    if (q > 32767) begin
      r.smp = 16'sh7fff;
    end else if (q < -32768) begin
      r.smp = 16'sh8000;
    end else begin
      r.smp = q[15:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  function automatic void apply_reg(input logic [IdxW-1:0] idx, input logic [CoefW-1:0] val);
    case (idx)
      REG_ENABLE:  filt_on = val[0];
      REG_COEF_B0: cb0 = val;
      REG_COEF_B1: cb1 = val;
      REG_COEF_B2: cb2 = val;
      REG_COEF_A1: ca1 = val;
      REG_COEF_A2: ca2 = val;
      default: ;
    endcase
  endfunction

  function automatic logic [CoefW-1:0] pick_coef(input int kind, input int lim);
    int v;
    case (kind)
      1: begin
        v = int'($urandom_range(0, 2 * lim)) - lim;
        return v[CoefW-1:0];
      end
      2: begin
        case ($urandom_range(0, 4))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'h000000;
          3: return 24'h000001;
          default: return 24'hFFFFFF;
        endcase
      end
      default: return CoefW'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CoefW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic add_sample(input int v, input logic clr);
    audio_item_t it;
    it.smp = v[15:0];
    it.clr = clr;
    pending_samples.push_back(it);
  endtask

  // Wait until every queued sample has gone in and every output has come back.
  task automatic settle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || due_outputs.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  // Sample driver: records each input transfer with the predictor, then offers the next one.
  always @(posedge clk) begin : drive_proc
    audio_item_t got;
    audio_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        got.smp = sample_in;
        got.clr = clear_state;
        due_outputs.push_back(filter_sample(got));
      end
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          nxt = pending_samples.pop_front();
          in_valid    <= 1'b1;
          sample_in   <= nxt.smp;
          clear_state <= nxt.clr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and receiver back-pressure, including one long hold-off.
  always @(posedge clk) begin : watch_proc
    audio_res_t want;
    int hold_left;
    bit hold_done;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        outputs_seen++;
        if (due_outputs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output %0d arrived with nothing pending: out=%0d clip=%0b",
                     outputs_seen, sample_out, clipped);
        end else begin
          want = due_outputs.pop_front();
          if (want.smp !== sample_out || want.clip !== clipped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("output %0d: expected out=%0d clip=%0b, got out=%0d clip=%0b",
                       outputs_seen, want.smp, want.clip, sample_out, clipped);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_arm && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      out_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [CoefW-1:0] en_word;
    int kind;
    int v;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Bypass straight after reset, with clears while disabled.
    @(negedge clk);
    add_sample(32767, 1'b0);
    add_sample(-32768, 1'b1);
    add_sample(0, 1'b0);
    add_sample(-1, 1'b0);
    add_sample(21845, 1'b0);
    add_sample(-21846, 1'b1);
    settle();

    // Enabled with the reset coefficients, which form a unity filter.
    write_reg(REG_ENABLE, 24'h000001);
    @(negedge clk);
    add_sample(32767, 1'b0);
    add_sample(-32768, 1'b0);
    add_sample(1, 1'b0);
    settle();

    // Extreme coefficients drive the state and the output into saturation.
    write_reg(REG_COEF_B0, 24'h7FFFFF);
    write_reg(REG_COEF_B1, 24'h7FFFFF);
    write_reg(REG_COEF_B2, 24'h800000);
    write_reg(REG_COEF_A1, 24'h800000);
    write_reg(REG_COEF_A2, 24'h7FFFFF);
    @(negedge clk);
    add_sample(32767, 1'b1);
    add_sample(-32768, 1'b0);
    add_sample(100, 1'b0);
    add_sample(-5, 1'b0);
    add_sample(0, 1'b0);
    settle();

    // Writes to unused indexes change nothing; enable takes only its low bit.
    write_reg(IDX_SPARE_LO, 24'hFFFFFF);
    write_reg(IDX_SPARE_HI, 24'hFFFFFF);
    write_reg(REG_ENABLE, 24'hFFFFFE);
    @(negedge clk);
    add_sample(1234, 1'b1);
    settle();

    // With b0 at zero the first output shows whether the clear above took effect.
    write_reg(REG_ENABLE, 24'h000001);
    write_reg(REG_COEF_B0, 24'h000000);
    @(negedge clk);
    add_sample(5000, 1'b0);
    add_sample(5000, 1'b0);
    add_sample(-32768, 1'b0);
    settle();
    write_reg(REG_COEF_B0, 24'h800000);
    @(negedge clk);
    add_sample(-32768, 1'b1);
    add_sample(32767, 1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      kind = PhaseKind[p];
      en_word = CoefW'($urandom);
      en_word[0] = (kind != 3);
      write_reg(REG_ENABLE, en_word);
      write_reg(REG_COEF_B0, pick_coef(kind, 1 << 20));
      write_reg(REG_COEF_B1, pick_coef(kind, 1 << 20));
      write_reg(REG_COEF_B2, pick_coef(kind, 1 << 20));
      write_reg(REG_COEF_A1, pick_coef(kind, 1 << 19));
      write_reg(REG_COEF_A2, pick_coef(kind, 1 << 19));
      @(negedge clk);
      send_gap_pct   = GapPct[p % 4];
      recv_stall_pct = StallPct[p % 4];
      // The first phase never idles the sender, so the long hold-off fills the block.
      if (p == 0)
        hold_arm = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(0, 1))
          v = $urandom_range(0, 65535);
        else
          v = int'($urandom_range(0, 2047)) - 1024;
        add_sample(v, $urandom_range(0, 99) < 4);
      end
      settle();
    end

    mismatches += due_outputs.size();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
